FILE: rtl/sdkr_pkg.sv
// ----------------------------------------------------------------------------
// sdkr_pkg
// Shared types and constants for the stick dead zone / key ramp conditioner.
// ----------------------------------------------------------------------------
package sdkr_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned THRESH_W = 15;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned PROD_W   = 32;
    localparam int unsigned FRAC_W   = 12;

    localparam logic signed [SAMPLE_W-1:0] Q15_ONE  = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] Q15_DIAG = 16'sd23170;
    localparam logic [THRESH_W-1:0]        Q15_MAG_ONE = 15'd32767;
    localparam logic [PROD_W:0]            ROUND_HALF = 33'd2048;

    localparam logic [THRESH_W-1:0] DZ_MIN_RESET  = 15'd9830;
    localparam logic [THRESH_W-1:0] DZ_MAX_RESET  = 15'd32767;
    localparam logic [GAIN_W-1:0]   DZ_GAIN_RESET = 16'd5851;

    typedef enum logic [1:0] {
        CFG_DZ_MIN  = 2'd0,
        CFG_DZ_MAX  = 2'd1,
        CFG_DZ_GAIN = 2'd2
    } cfg_index_t;

    // dead zone settings shared by both lanes
    typedef struct packed {
        logic [THRESH_W-1:0] dz_min;
        logic [THRESH_W-1:0] dz_max;
        logic [GAIN_W-1:0]   dz_gain;
    } dz_cfg_t;

    // per-frame controls that ride along with the stick lanes
    typedef struct packed {
        logic              pad_present;
        logic              key_right;
        logic              key_left;
        logic              key_down;
        logic              key_up;
        logic [STEP_W-1:0] ramp_step;
    } frame_ctl_t;

    // pipeline advance enables
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } pipe_en_t;

endpackage

FILE: rtl/sdkr_lane.sv
// ----------------------------------------------------------------------------
// sdkr_lane
// One stick axis through the dead zone: magnitude, thresholds and gain
// multiply in the first stage, rounding, saturation and sign in the second.
// ----------------------------------------------------------------------------
module sdkr_lane
(
    input  logic                                   clk,
    input  logic                                   en_a,
    input  logic                                   en_b,
    input  logic signed [sdkr_pkg::SAMPLE_W-1:0]   sample,
    input  sdkr_pkg::dz_cfg_t                      cfg,
    output logic signed [sdkr_pkg::SAMPLE_W-1:0]   dz_value
);
    import sdkr_pkg::*;

    logic [SAMPLE_W-1:0]        mag;
    logic [SAMPLE_W-1:0]        diff;
    logic                       below_next;
    logic                       above_next;
    logic [PROD_W-1:0]          prod_next;

    logic                       below_reg;
    logic                       above_reg;
    logic                       neg_reg;
    logic [PROD_W-1:0]          prod_reg;

    logic [PROD_W:0]            rounded;
    logic [PROD_W-FRAC_W:0]     scaled;
    logic [THRESH_W-1:0]        lin_mag;
    logic signed [SAMPLE_W-1:0] value_next;
    logic signed [SAMPLE_W-1:0] value_reg;

    // magnitude of the most negative sample fits as 0x8000
    always_comb
    begin
        mag        = sample[SAMPLE_W-1] ? (~sample + 16'd1) : sample;
        below_next = mag < {1'b0, cfg.dz_min};
        above_next = mag > {1'b0, cfg.dz_max};
        diff       = mag - {1'b0, cfg.dz_min};
        prod_next  = diff * cfg.dz_gain;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            below_reg <= below_next;
            above_reg <= above_next;
            neg_reg   <= sample[SAMPLE_W-1];
            prod_reg  <= prod_next;
        end
    end

    always_comb
    begin
        rounded = {1'b0, prod_reg} + ROUND_HALF;
        scaled  = rounded[PROD_W:FRAC_W];
        if (scaled > {{(PROD_W-FRAC_W-THRESH_W+1){1'b0}}, Q15_MAG_ONE})
            lin_mag = Q15_MAG_ONE;
        else
            lin_mag = scaled[THRESH_W-1:0];

        priority if (below_reg)
            value_next = '0;
        else if (above_reg)
            value_next = neg_reg ? -Q15_ONE : Q15_ONE;
        else
            value_next = neg_reg ? -$signed({1'b0, lin_mag}) : $signed({1'b0, lin_mag});
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            value_reg <= value_next;
    end

    assign dz_value = value_reg;

endmodule

FILE: rtl/sdkr_merge.sv
// ----------------------------------------------------------------------------
// sdkr_merge
// Combines both lanes: pad override or keyboard target, then the ramp that
// moves the held axes toward the target.
// ----------------------------------------------------------------------------
module sdkr_merge
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   update,
    input  logic signed [sdkr_pkg::SAMPLE_W-1:0]   dz_x,
    input  logic signed [sdkr_pkg::SAMPLE_W-1:0]   dz_y,
    input  sdkr_pkg::frame_ctl_t                   ctl,
    output logic signed [sdkr_pkg::SAMPLE_W-1:0]   held_x,
    output logic signed [sdkr_pkg::SAMPLE_W-1:0]   held_y
);
    import sdkr_pkg::*;

    logic signed [SAMPLE_W-1:0] held_x_reg;
    logic signed [SAMPLE_W-1:0] held_y_reg;
    logic signed [SAMPLE_W-1:0] held_x_next;
    logic signed [SAMPLE_W-1:0] held_y_next;
    logic signed [SAMPLE_W-1:0] tgt_x;
    logic signed [SAMPLE_W-1:0] tgt_y;

    function automatic logic signed [SAMPLE_W-1:0] ramp_to(
        input logic signed [SAMPLE_W-1:0] h,
        input logic signed [SAMPLE_W-1:0] t,
        input logic [STEP_W-1:0]          r
    );
        logic signed [SAMPLE_W+1:0] h_w;
        logic signed [SAMPLE_W+1:0] t_w;
        logic signed [SAMPLE_W+1:0] r_w;
        logic signed [SAMPLE_W+1:0] up;
        logic signed [SAMPLE_W+1:0] dn;
        logic signed [SAMPLE_W-1:0] res;
        h_w = {{2{h[SAMPLE_W-1]}}, h};
        t_w = {{2{t[SAMPLE_W-1]}}, t};
        r_w = {3'b000, r};
        up  = h_w + r_w;
        dn  = h_w - r_w;
        priority if (h_w < t_w)
            res = (up < t_w) ? up[SAMPLE_W-1:0] : t;
        else if (h_w > t_w)
            res = (dn > t_w) ? dn[SAMPLE_W-1:0] : t;
        else
            res = h;
        return res;
    endfunction

    always_comb
    begin
        // left beats right, up beats down
        priority if (ctl.key_left)
            tgt_x = -Q15_ONE;
        else if (ctl.key_right)
            tgt_x = Q15_ONE;
        else
            tgt_x = '0;

        priority if (ctl.key_up)
            tgt_y = -Q15_ONE;
        else if (ctl.key_down)
            tgt_y = Q15_ONE;
        else
            tgt_y = '0;

        // diagonal is scaled to unit length
        if ((tgt_x != '0) && (tgt_y != '0))
        begin
            tgt_x = ctl.key_left ? -Q15_DIAG : Q15_DIAG;
            tgt_y = ctl.key_up   ? -Q15_DIAG : Q15_DIAG;
        end

        if (ctl.pad_present && ((dz_x != '0) || (dz_y != '0)))
        begin
            held_x_next = dz_x;
            held_y_next = dz_y;
        end
        else
        begin
            held_x_next = ramp_to(held_x_reg, tgt_x, ctl.ramp_step);
            held_y_next = ramp_to(held_y_reg, tgt_y, ctl.ramp_step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg <= '0;
            held_y_reg <= '0;
        end
        else if (update)
        begin
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

    assign held_x = held_x_reg;
    assign held_y = held_y_reg;

endmodule

FILE: rtl/stick_deadzone_with_key_ramp.sv
// ----------------------------------------------------------------------------
// stick_deadzone_with_key_ramp
// Per-frame move-axis conditioner: stick dead zone with keyboard ramp.
// ----------------------------------------------------------------------------
// One frame per cycle is taken unless the output stalls. A frame passes from
// input transfer to a valid result through two stages in each axis lane
// (gain multiply, then round and saturate) and one merge stage that updates
// the held axes, which are the output register. The held-axis feedback
// closes inside the merge stage, so back-to-back frames see each other's
// ramp state. Output back pressure stalls only full stages, and in_ready
// stays high as long as some stage is free. Configuration writes are always
// taken (cfg_ready is tied high) and should be made while idle.
// ----------------------------------------------------------------------------
module stick_deadzone_with_key_ramp
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [15:0]                            cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [sdkr_pkg::SAMPLE_W-1:0]   stick_x,
    input  logic signed [sdkr_pkg::SAMPLE_W-1:0]   stick_y,
    input  logic                                   pad_present,
    input  logic                                   key_right,
    input  logic                                   key_left,
    input  logic                                   key_down,
    input  logic                                   key_up,
    input  logic [sdkr_pkg::STEP_W-1:0]            ramp_step,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [sdkr_pkg::SAMPLE_W-1:0]   move_x,
    output logic signed [sdkr_pkg::SAMPLE_W-1:0]   move_y
);
    import sdkr_pkg::*;

    dz_cfg_t    cfg_reg;
    dz_cfg_t    cfg_next;
    pipe_en_t   en;
    frame_ctl_t ctl_in;
    frame_ctl_t ctl_a_reg;
    frame_ctl_t ctl_b_reg;

    logic       v_a_reg;
    logic       v_b_reg;
    logic       out_valid_reg;
    logic       v_a_next;
    logic       v_b_next;
    logic       out_valid_next;

    logic signed [SAMPLE_W-1:0] dz_x;
    logic signed [SAMPLE_W-1:0] dz_y;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DZ_MIN:  cfg_next.dz_min  = cfg_data[THRESH_W-1:0];
                CFG_DZ_MAX:  cfg_next.dz_max  = cfg_data[THRESH_W-1:0];
                CFG_DZ_GAIN: cfg_next.dz_gain = cfg_data[GAIN_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dz_min  <= DZ_MIN_RESET;
            cfg_reg.dz_max  <= DZ_MAX_RESET;
            cfg_reg.dz_gain <= DZ_GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline control; a stage stalls only while it and every later stage are full
    always_comb
    begin
        en.en_c  = !out_valid_reg || out_ready;
        en.en_b  = !v_b_reg || en.en_c;
        en.en_a  = !v_a_reg || en.en_b;
        in_ready = en.en_a;

        v_a_next       = en.en_a ? in_valid : v_a_reg;
        v_b_next       = en.en_b ? v_a_reg  : v_b_reg;
        out_valid_next = en.en_c ? v_b_reg  : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg       <= 1'b0;
            v_b_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_a_reg       <= v_a_next;
            v_b_reg       <= v_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ctl_in.pad_present = pad_present;
    assign ctl_in.key_right   = key_right;
    assign ctl_in.key_left    = key_left;
    assign ctl_in.key_down    = key_down;
    assign ctl_in.key_up      = key_up;
    assign ctl_in.ramp_step   = ramp_step;

    always_ff @(posedge clk)
    begin
        if (en.en_a)
            ctl_a_reg <= ctl_in;
        if (en.en_b)
            ctl_b_reg <= ctl_a_reg;
    end

    sdkr_lane u_lane_x
    (
        .clk      (clk),
        .en_a     (en.en_a),
        .en_b     (en.en_b),
        .sample   (stick_x),
        .cfg      (cfg_reg),
        .dz_value (dz_x)
    );

    sdkr_lane u_lane_y
    (
        .clk      (clk),
        .en_a     (en.en_a),
        .en_b     (en.en_b),
        .sample   (stick_y),
        .cfg      (cfg_reg),
        .dz_value (dz_y)
    );

    // held axes move only when a frame leaves the lanes
    sdkr_merge u_merge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (en.en_c && v_b_reg),
        .dz_x   (dz_x),
        .dz_y   (dz_y),
        .ctl    (ctl_b_reg),
        .held_x (move_x),
        .held_y (move_y)
    );

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/sdkr_checker.sv
// ----------------------------------------------------------------------------
// sdkr_checker
// Port-level checks for the stick conditioner, bound to the top level.
// ----------------------------------------------------------------------------
module sdkr_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_ready,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [sdkr_pkg::SAMPLE_W-1:0]   move_x,
    input  logic signed [sdkr_pkg::SAMPLE_W-1:0]   move_y
);
    import sdkr_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(move_x) && $stable(move_y))
        else $error("result changed while stalled");

    // input side only blocks when the output is full and stalled
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output back pressure");

    // held axes never reach the most negative code
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (move_x != -Q15_ONE - 16'sd1) && (move_y != -Q15_ONE - 16'sd1))
        else $error("move axis out of range");

endmodule

bind stick_deadzone_with_key_ramp sdkr_checker u_sdkr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .move_x    (move_x),
    .move_y    (move_y)
);

FILE: bench/tb_stick_deadzone_with_key_ramp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stick_deadzone_with_key_ramp
// Drives frames through the stick dead zone / key ramp conditioner in bursts
// while the result side stalls on rotating patterns. Each accepted frame is
// run through a local model of the dead zone, keyboard target and ramp, and
// every result transfer is checked field by field against the oldest
// predicted move. Configuration phases cover the default, extreme and random
// dead zone settings, including an inverted threshold pair and zero gain.
// ----------------------------------------------------------------------------
module tb_stick_deadzone_with_key_ramp;

    import sdkr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [3:0] KEY_R = 4'b0001;
    localparam logic [3:0] KEY_L = 4'b0010;
    localparam logic [3:0] KEY_D = 4'b0100;
    localparam logic [3:0] KEY_U = 4'b1000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sx;
        logic signed [SAMPLE_W-1:0] sy;
        logic                       pad;
        logic [3:0]                 keys;
        logic [STEP_W-1:0]          step;
    } frame_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] mx;
        logic signed [SAMPLE_W-1:0] my;
    } move_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = '0;
    logic [15:0]                cfg_data = '0;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] stick_x = '0;
    logic signed [SAMPLE_W-1:0] stick_y = '0;
    logic                       pad_present = 1'b0;
    logic                       key_right = 1'b0;
    logic                       key_left = 1'b0;
    logic                       key_down = 1'b0;
    logic                       key_up = 1'b0;
    logic [STEP_W-1:0]          ramp_step = '0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] move_x;
    logic signed [SAMPLE_W-1:0] move_y;

    // local copy of the block's settings and held axes
    logic [THRESH_W-1:0]        dz_min_m = DZ_MIN_RESET;
    logic [THRESH_W-1:0]        dz_max_m = DZ_MAX_RESET;
    logic [GAIN_W-1:0]          dz_gain_m = DZ_GAIN_RESET;
    logic signed [SAMPLE_W-1:0] held_x = '0;
    logic signed [SAMPLE_W-1:0] held_y = '0;

    frame_t frames_todo[$];
    move_t  expected_moves[$];
    frame_t cur_frame;
    int     frames_queued = 0;
    int     results_seen = 0;
    int     errors = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    logic [7:0] stall_pat = 8'hFF;
    int     stall_cnt = 0;

    stick_deadzone_with_key_ramp dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stick_x     (stick_x),
        .stick_y     (stick_y),
        .pad_present (pad_present),
        .key_right   (key_right),
        .key_left    (key_left),
        .key_down    (key_down),
        .key_up      (key_up),
        .ramp_step   (ramp_step),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .move_x      (move_x),
        .move_y      (move_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("tb_stick_deadzone_with_key_ramp: errors");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // dead zone, linear rescale with round half up, saturation
    function automatic int shape_axis(input logic signed [SAMPLE_W-1:0] s);
        int     m;
        int     v;
        longint p;
        m = (s < 0) ? -int'(s) : int'(s);
        if (m < int'(dz_min_m))
            return 0;
        if (m > int'(dz_max_m))
            v = int'(Q15_ONE);
        else
        begin
            p = (longint'(m - int'(dz_min_m)) * longint'(dz_gain_m) + 2048) >>> FRAC_W;
            v = (p > longint'(Q15_ONE)) ? int'(Q15_ONE) : int'(p);
        end
        return (s < 0) ? -v : v;
    endfunction

    function automatic int slew_toward(input int h, input int t, input int r);
        if (h < t)
            return (h + r < t) ? h + r : t;
        if (h > t)
            return (h - r > t) ? h - r : t;
        return h;
    endfunction

    task automatic advance_held_axes(input frame_t f);
        int    dx;
        int    dy;
        int    tx;
        int    ty;
        move_t e;
        dx = shape_axis(f.sx);
        dy = shape_axis(f.sy);
        if (f.pad && (dx != 0 || dy != 0))
        begin
            held_x = dx[SAMPLE_W-1:0];
            held_y = dy[SAMPLE_W-1:0];
        end
        else
        begin
            tx = 0;
            ty = 0;
            if (f.keys & KEY_R) tx = int'(Q15_ONE);
            if (f.keys & KEY_L) tx = -int'(Q15_ONE);
            if (f.keys & KEY_D) ty = int'(Q15_ONE);
            if (f.keys & KEY_U) ty = -int'(Q15_ONE);
            // diagonal gets scaled by sqrt(0.5)
            if (tx != 0 && ty != 0)
            begin
                tx = (tx > 0) ? int'(Q15_DIAG) : -int'(Q15_DIAG);
                ty = (ty > 0) ? int'(Q15_DIAG) : -int'(Q15_DIAG);
            end
            held_x = SAMPLE_W'(slew_toward(int'(held_x), tx, int'(f.step)));
            held_y = SAMPLE_W'(slew_toward(int'(held_y), ty, int'(f.step)));
        end
        e.mx = held_x;
        e.my = held_y;
        expected_moves.push_back(e);
    endtask

    function automatic frame_t make_frame(input int sx, input int sy, input logic pad,
                                          input logic [3:0] keys, input int step);
        frame_t f;
        f.sx = sx[SAMPLE_W-1:0];
        f.sy = sy[SAMPLE_W-1:0];
        f.pad = pad;
        f.keys = keys;
        f.step = step[STEP_W-1:0];
        return f;
    endfunction

    task automatic queue_frame(input frame_t f);
        frames_todo.push_back(f);
        frames_queued++;
    endtask

    // sample strictly inside the current inner threshold
    function automatic int quiet_stick();
        int m;
        if (dz_min_m == 0)
            return 0;
        m = $urandom_range(0, int'(dz_min_m) - 1);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic int pick_stick();
        int b;
        case ($urandom_range(0, 7))
            0: b = -32768;
            1: b = 32767;
            2: b = -32767;
            3: b = int'(dz_min_m) + $urandom_range(0, 2) - 1;
            4: b = int'(dz_max_m) + $urandom_range(0, 1);
            5: b = quiet_stick();
            default: b = int'($signed(16'($urandom)));
        endcase
        if (b > 32767)
            b = 32767;
        if ($urandom_range(0, 1) && b > 0)
            b = -b;
        return b;
    endfunction

    function automatic int pick_step();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32767;
            2, 3: return int'(15'($urandom));
            default: return $urandom_range(1, 6000);
        endcase
    endfunction

    task automatic run_random(input int n);
        int         added;
        int         len;
        int         step;
        logic [3:0] keys;
        logic       pad;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // held keys over several frames, pad mostly quiet
                keys = 4'($urandom);
                step = pick_step();
                len = $urandom_range(3, 16);
                repeat (len)
                begin
                    pad = 1'($urandom);
                    if ($urandom_range(0, 7) == 0)
                        queue_frame(make_frame(pick_stick(), pick_stick(), pad, keys, step));
                    else
                        queue_frame(make_frame(quiet_stick(), quiet_stick(), pad, keys, step));
                end
                added += len;
            end
            else
            begin
                queue_frame(make_frame(pick_stick(), pick_stick(), 1'($urandom),
                                       4'($urandom), pick_step()));
                added++;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DZ_MIN:  dz_min_m = val[THRESH_W-1:0];
            CFG_DZ_MAX:  dz_max_m = val[THRESH_W-1:0];
            CFG_DZ_GAIN: dz_gain_m = val;
            default: ;
        endcase
    endtask

    task automatic set_dead_zone(input int mn, input int mx, input int gain);
        // top bit of the threshold writes is dropped by the block
        write_reg(CFG_DZ_MIN, {1'($urandom), mn[THRESH_W-1:0]});
        write_reg(CFG_DZ_MAX, {1'($urandom), mx[THRESH_W-1:0]});
        write_reg(CFG_DZ_GAIN, gain[GAIN_W-1:0]);
    endtask

    task automatic wait_drained();
        while (results_seen < frames_queued)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_held_axes(cur_frame);
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (frames_todo.size() != 0)
                begin
                    cur_frame = frames_todo.pop_front();
                    in_valid <= 1'b1;
                    stick_x <= cur_frame.sx;
                    stick_y <= cur_frame.sy;
                    pad_present <= cur_frame.pad;
                    key_right <= |(cur_frame.keys & KEY_R);
                    key_left <= |(cur_frame.keys & KEY_L);
                    key_down <= |(cur_frame.keys & KEY_D);
                    key_up <= |(cur_frame.keys & KEY_U);
                    ramp_step <= cur_frame.step;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 7);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: check each result transfer, stall on a rotating pattern
    always @(posedge clk)
    begin
        move_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_moves.size() == 0)
                    report($sformatf("result with nothing expected: x=%0d y=%0d",
                                     move_x, move_y));
                else
                begin
                    e = expected_moves.pop_front();
                    if (move_x !== e.mx)
                        report($sformatf("move_x got %0d exp %0d", move_x, e.mx));
                    if (move_y !== e.my)
                        report($sformatf("move_y got %0d exp %0d", move_y, e.my));
                end
            end
            if (stall_cnt == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1: stall_pat = 8'hFF;
                    2: stall_pat = 8'($urandom) | 8'h01;
                    default: stall_pat = 8'h5A;
                endcase
                stall_cnt = $urandom_range(8, 80);
            end
            else
                stall_cnt--;
            out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
    end

    initial
    begin
        int mn;
        int mx;
        int gain;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: thresholds, saturation, key priority and diagonals
        queue_frame(make_frame(0, 0, 1'b1, 4'b0000, 0));
        queue_frame(make_frame(32767, -32768, 1'b1, 4'b0000, 0));
        queue_frame(make_frame(9830, 9829, 1'b1, 4'b0000, 100));
        queue_frame(make_frame(-9830, -32767, 1'b1, 4'b0000, 100));
        queue_frame(make_frame(-9829, 9831, 1'b1, 4'b0000, 100));
        queue_frame(make_frame(32767, 32767, 1'b0, KEY_R, 32767));
        queue_frame(make_frame(0, 0, 1'b0, KEY_L | KEY_R, 1000));
        queue_frame(make_frame(0, 0, 1'b0, KEY_L | KEY_R, 32767));
        queue_frame(make_frame(0, 0, 1'b0, KEY_U | KEY_D, 20000));
        queue_frame(make_frame(0, 0, 1'b0, KEY_D, 32767));
        queue_frame(make_frame(0, 0, 1'b0, KEY_R | KEY_D, 32767));
        queue_frame(make_frame(0, 0, 1'b0, KEY_L | KEY_U, 5000));
        queue_frame(make_frame(0, 0, 1'b0, KEY_L | KEY_U, 32767));
        queue_frame(make_frame(0, 0, 1'b0, 4'b1111, 32767));
        queue_frame(make_frame(0, 0, 1'b0, 4'b0000, 0));
        queue_frame(make_frame(0, 0, 1'b0, 4'b0000, 7000));
        queue_frame(make_frame(0, 0, 1'b0, 4'b0000, 7000));
        queue_frame(make_frame(0, 0, 1'b0, 4'b0000, 32767));
        queue_frame(make_frame(-500, 9000, 1'b1, KEY_R, 12000));
        queue_frame(make_frame(-32768, -32768, 1'b0, KEY_U, 30000));
        queue_frame(make_frame(-32768, 0, 1'b1, KEY_D, 1));
        queue_frame(make_frame(0, 32767, 1'b1, KEY_L, 1));
        wait_drained();

        // unity gain, no inner zone
        set_dead_zone(0, 32767, 4096);
        run_random(55);
        wait_drained();

        // min above max: everything outside zero saturates
        set_dead_zone(32767, 0, 65535);
        run_random(55);
        wait_drained();

        // zero gain: linear region collapses, keys take over
        set_dead_zone(4000, 30000, 0);
        run_random(55);
        wait_drained();

        // out of range index must not land anywhere
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_dead_zone(0, 0, 65535);
        write_reg(CFG_UNUSED, 16'h0000);
        run_random(55);
        wait_drained();

        repeat (6)
        begin
            mn = $urandom_range(0, 32767);
            if ($urandom_range(0, 4) == 0)
                mx = $urandom_range(0, 32767);
            else
                mx = $urandom_range(mn, 32767);
            if (mx > mn && $urandom_range(0, 3) != 0)
            begin
                gain = (1 << 27) / (mx - mn);
                if (gain > 65535)
                    gain = 65535;
            end
            else
                gain = int'(16'($urandom));
            set_dead_zone(mn, mx, gain);
            run_random(80);
            wait_drained();
        end

        if (expected_moves.size() != 0)
            report($sformatf("%0d expected moves never arrived", expected_moves.size()));
        if (errors == 0)
            $display("tb_stick_deadzone_with_key_ramp: clean");
        else
            $display("tb_stick_deadzone_with_key_ramp: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sdkr_pkg.sv
rtl/sdkr_lane.sv
rtl/sdkr_merge.sv
rtl/stick_deadzone_with_key_ramp.sv
rtl/sdkr_checker.sv
bench/tb_stick_deadzone_with_key_ramp.sv
